// ===== hdl/cst_pkg.sv =====
// Channel slot table package: command and result item types, mode and status codes,
// and the store control group. No dependencies.
package cst_pkg;

  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_CLOSE  = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_QUOTA     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [4:0] QUOTA_RESET = 5'd8;
  localparam logic [31:0] ID_FIRST   = 32'd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] owner;
    logic [31:0] lookup_id;
  } cst_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [31:0] channel_id;
    logic [4:0]  freed_count;
  } cst_res_t;

  typedef struct packed {
    logic wr_en;
    logic act_clr;
    logic clr_all;
  } cst_ctl_t;

endpackage

// ===== hdl/cst_store.sv =====
// Slot storage: owner and channel id memories with registered read, active flags in flops.
// Depends on cst_pkg.
module cst_store #(
  parameter int SLOTS = 16,
  parameter int IW    = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cst_pkg::cst_ctl_t  ctl_i,
  input  logic [IW-1:0]      wr_idx_i,
  input  logic [31:0]        wr_owner_i,
  input  logic [31:0]        wr_id_i,
  input  logic [IW-1:0]      rd_idx_i,
  output logic               rd_act_o,
  output logic [31:0]        rd_owner_o,
  output logic [31:0]        rd_id_o
);
  import cst_pkg::*;

  logic [31:0]      owner_mem [SLOTS];
  logic [31:0]      id_mem    [SLOTS];
  logic [SLOTS-1:0] active_q;
  logic             rd_act_q;
  logic [31:0]      rd_owner_q;
  logic [31:0]      rd_id_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      owner_mem[wr_idx_i] <= wr_owner_i;
      id_mem[wr_idx_i]    <= wr_id_i;
    end
    rd_owner_q <= owner_mem[rd_idx_i];
    rd_id_q    <= id_mem[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      rd_act_q <= 1'b0;
    end else begin
      rd_act_q <= active_q[rd_idx_i];
      if (ctl_i.clr_all) begin
        active_q <= '0;
      end else if (ctl_i.wr_en) begin
        active_q[wr_idx_i] <= 1'b1;
      end else if (ctl_i.act_clr) begin
        active_q[wr_idx_i] <= 1'b0;
      end
    end
  end

  assign rd_act_o   = rd_act_q;
  assign rd_owner_o = rd_owner_q;
  assign rd_id_o    = rd_id_q;

endmodule

// ===== hdl/cst_ctrl.sv =====
// Scan sequencer: walks the slots through one shared match and count unit per pass.
// Depends on cst_pkg; drives cst_store.
module cst_ctrl #(
  parameter int SLOTS = 16,
  parameter int IW    = 4,
  parameter int CW    = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  cst_pkg::cst_cmd_t  cmd_i,
  input  logic [4:0]         quota_i,
  output logic               busy,
  output logic               done_o,
  output cst_pkg::cst_res_t  res_o,
  output cst_pkg::cst_ctl_t  ctl_o,
  output logic [IW-1:0]      wr_idx_o,
  output logic [31:0]        wr_owner_o,
  output logic [31:0]        wr_id_o,
  output logic [IW-1:0]      rd_idx_o,
  input  logic               rd_act_i,
  input  logic [31:0]        rd_owner_i,
  input  logic [31:0]        rd_id_i
);
  import cst_pkg::*;

  localparam int QW = (CW > 5) ? CW : 5;

  typedef enum logic [2:0] {
    IDLE, COUNT, FREE, LOOKUP, CLOSE
  } state_e;

  state_e      state_q;
  logic [31:0] owner_q;
  logic [31:0] want_q;
  logic [31:0] next_id_q;
  logic [CW-1:0] idx_q;
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] pidx_q;
  logic        pend_q;
  logic        done_q;
  cst_res_t    res_q;

  logic          accept;
  logic          in_range;
  logic          match;
  logic          last;
  logic [CW-1:0] cnt_nx;

  assign accept   = start && (state_q == IDLE);
  assign in_range = idx_q < CW'(SLOTS);
  assign match    = (state_q == FREE) ? !rd_act_i :
                    (rd_act_i && (rd_owner_i == owner_q) &&
                     ((state_q != LOOKUP) || (rd_id_i == want_q)));
  assign last     = pidx_q == IW'(SLOTS - 1);
  assign cnt_nx   = cnt_q + CW'(match);

  assign rd_idx_o   = in_range ? idx_q[IW-1:0] : '0;
  assign wr_idx_o   = pidx_q;
  assign wr_owner_o = owner_q;
  assign wr_id_o    = next_id_q;

  always_comb begin
    ctl_o         = '0;
    ctl_o.wr_en   = (state_q == FREE) && pend_q && match;
    ctl_o.act_clr = (state_q == CLOSE) && pend_q && match;
    ctl_o.clr_all = accept && (cmd_i.mode == MODE_CLEAR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= IDLE;
      next_id_q <= ID_FIRST;
      idx_q     <= '0;
      cnt_q     <= '0;
      pidx_q    <= '0;
      pend_q    <= 1'b0;
      done_q    <= 1'b0;
      res_q     <= '0;
      owner_q   <= '0;
      want_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        IDLE: begin
          if (start) begin
            owner_q <= cmd_i.owner;
            want_q  <= cmd_i.lookup_id;
            cnt_q   <= '0;
            idx_q   <= '0;
            pend_q  <= 1'b0;
            case (cmd_i.mode)
              MODE_ALLOC:  state_q <= COUNT;
              MODE_LOOKUP: state_q <= LOOKUP;
              MODE_CLOSE:  state_q <= CLOSE;
              default: begin
                next_id_q <= ID_FIRST;
                res_q     <= '0;
                done_q    <= 1'b1;
              end
            endcase
          end
        end
        default: begin
          // advance the read pointer; pidx follows idx through a register, so it matches the registered read data
          if (in_range) idx_q <= idx_q + CW'(1);
          pend_q <= in_range;
          pidx_q <= in_range ? idx_q[IW-1:0] : pidx_q;
          if (pend_q) begin
            case (state_q)
              COUNT: begin
                cnt_q <= cnt_nx;
                if (last) begin
                  if (QW'(cnt_nx) >= QW'(quota_i)) begin
                    res_q        <= '0;
                    res_q.status <= ST_QUOTA;
                    done_q       <= 1'b1;
                    state_q      <= IDLE;
                  end else begin
                    state_q <= FREE;
                    idx_q   <= '0;
                    pend_q  <= 1'b0;
                  end
                end
              end
              FREE: begin
                if (match) begin
                  res_q.status      <= ST_OK;
                  res_q.slot        <= 4'(pidx_q);
                  res_q.channel_id  <= next_id_q;
                  res_q.freed_count <= '0;
                  next_id_q         <= next_id_q + 32'd1;
                  done_q            <= 1'b1;
                  state_q           <= IDLE;
                end else if (last) begin
                  res_q        <= '0;
                  res_q.status <= ST_FULL;
                  done_q       <= 1'b1;
                  state_q      <= IDLE;
                end
              end
              LOOKUP: begin
                if (match) begin
                  res_q.status      <= ST_OK;
                  res_q.slot        <= 4'(pidx_q);
                  res_q.channel_id  <= rd_id_i;
                  res_q.freed_count <= '0;
                  done_q            <= 1'b1;
                  state_q           <= IDLE;
                end else if (last) begin
                  res_q        <= '0;
                  res_q.status <= ST_NOT_FOUND;
                  done_q       <= 1'b1;
                  state_q      <= IDLE;
                end
              end
              default: begin
                cnt_q <= cnt_nx;
                if (last) begin
                  res_q             <= '0;
                  res_q.freed_count <= 5'(cnt_nx);
                  done_q            <= 1'b1;
                  state_q           <= IDLE;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  assign busy   = state_q != IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || start))
    else $error("result without a command");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result while still busy");

  a_one_store_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_o.wr_en && ctl_o.act_clr))
    else $error("slot set and cleared together");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status != ST_OK)) |->
      (res_o.slot == '0 && res_o.channel_id == '0 && res_o.freed_count == '0))
    else $error("failed item carries data");

endmodule

// ===== hdl/channel_slot_table_with_quota_top.sv =====
// Channel slot table with per-owner quota: top level with the quota register.
// Depends on cst_pkg, cst_store and cst_ctrl.
//
// Usage: drive cmd_i and pulse start while busy is low; the item is taken at
// that edge. Exactly one result appears on res_o with done_o high for one
// cycle; the receiver cannot stall it. busy stays high while a scan runs.
// Clear finishes without busy rising. Lookup and close scan the slots one per
// cycle through the registered memory read. Allocate counts the owner's slots,
// then, unless the quota is reached, searches for a free one. All scans pass
// through the shared match/count unit and the single memory read port.
// cfg_we_i writes the quota from cfg_wdata_i; the user must do this only while
// the block is idle, as the block itself does not enforce it.
// Reset empties the table, sets the id counter to 1 and the quota to 8.
module channel_slot_table_with_quota_top #(
  parameter int SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  cst_pkg::cst_cmd_t  cmd_i,
  output logic               done_o,
  output cst_pkg::cst_res_t  res_o,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i
);
  import cst_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  logic [4:0]    quota_q;
  cst_ctl_t      ctl;
  logic [IW-1:0] wr_idx;
  logic [31:0]   wr_owner;
  logic [31:0]   wr_id;
  logic [IW-1:0] rd_idx;
  logic          rd_act;
  logic [31:0]   rd_owner;
  logic [31:0]   rd_id;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quota_q <= QUOTA_RESET;
    end else if (cfg_we_i) begin
      quota_q <= cfg_wdata_i;
    end
  end

  cst_ctrl #(.SLOTS(SLOTS), .IW(IW), .CW(CW)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .cmd_i      (cmd_i),
    .quota_i    (quota_q),
    .busy       (busy),
    .done_o     (done_o),
    .res_o      (res_o),
    .ctl_o      (ctl),
    .wr_idx_o   (wr_idx),
    .wr_owner_o (wr_owner),
    .wr_id_o    (wr_id),
    .rd_idx_o   (rd_idx),
    .rd_act_i   (rd_act),
    .rd_owner_i (rd_owner),
    .rd_id_i    (rd_id)
  );

  cst_store #(.SLOTS(SLOTS), .IW(IW)) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .wr_idx_i   (wr_idx),
    .wr_owner_i (wr_owner),
    .wr_id_i    (wr_id),
    .rd_idx_i   (rd_idx),
    .rd_act_o   (rd_act),
    .rd_owner_o (rd_owner),
    .rd_id_o    (rd_id)
  );

endmodule
